// ----- rtl/bem_pkg.sv -----
package bem_pkg;

  localparam int unsigned MaxExtentsDefault = 256;
  localparam int unsigned EntryW = 128;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_DEALLOC = 3'd1,
    CMD_P2F     = 3'd2,
    CMD_F2P     = 3'd3,
    CMD_SIZE    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_FULL       = 3'd2,
    ST_BAD_EXTEND = 3'd3,
    ST_MIDDLE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] parity_start;
    logic [31:0] file;
    logic [31:0] file_start;
    logic [31:0] length;
  } extent_t;

endpackage

// ----- rtl/bem_ram.sv -----
module bem_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/block_extent_map.sv -----
// Extent map table. Each command scans every slot of the extent memory one
// per cycle: a read per slot, the registered read data checked as it returns,
// and a closing step. A write-back step follows, and then the result is
// presented. The single read port of the extent memory sets the scan length.
// One request is in flight at a time; in_stall is high from acceptance until
// its result has been taken. Valid bits live in flip-flops cleared by reset;
// the memory needs no clearing pass. For several matches the lowest slot wins;
// failed commands leave the table unchanged.
module block_extent_map #(
  parameter int unsigned MAX_EXTENTS = bem_pkg::MaxExtentsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_parity_pos,
  input  logic [31:0] in_file_id,
  input  logic [31:0] in_file_pos,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_found_file,
  output logic [31:0] out_found_file_pos,
  output logic [31:0] out_found_parity_pos,
  output logic [31:0] out_disk_extent_end
);

  localparam int unsigned AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW = AW + 1;

  bem_pkg::state_t state_r, state_nxt;

  logic [2:0]  cmd_r;
  logic [31:0] pp_r, fid_r, fpos_r;
  logic [MAX_EXTENTS-1:0] valid_r, valid_nxt;

  // scan: rd_cnt issues reads, chk_idx tags returning data
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          chk_v_r;
  logic [AW-1:0] chk_idx_r;

  // first hits of the scan, and the largest parity end seen
  logic          hit_p_r, hit_f_r, hit_e_r, free_v_r;
  logic [AW-1:0] hit_p_idx_r, hit_f_idx_r, free_idx_r;
  bem_pkg::extent_t hit_p_ent_r, hit_f_ent_r;
  logic [32:0] best_r;

  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  bem_pkg::extent_t ram_wdata, ram_rdata;

  logic [2:0]  st_r;
  logic [31:0] ff_r, fp_r, ppo_r, end_r;

  bem_ram #(.Width(bem_pkg::EntryW), .Depth(MAX_EXTENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // per-entry compares
  logic [32:0] p_end, f_end;
  logic        m_p, m_f, m_e, cur_v;
  logic [31:0] fpos_m1;

  assign fpos_m1 = fpos_r - 32'd1;
  assign cur_v   = chk_v_r && valid_r[chk_idx_r];
  assign p_end   = {1'b0, ram_rdata.parity_start} + {1'b0, ram_rdata.length};
  assign f_end   = {1'b0, ram_rdata.file_start} + {1'b0, ram_rdata.length};
  assign m_p = cur_v && ({1'b0, pp_r} >= {1'b0, ram_rdata.parity_start}) &&
               ({1'b0, pp_r} < p_end);
  // file match on pos for lookup, on pos-1 for allocate
  assign m_f = cur_v && (ram_rdata.file == fid_r) &&
               (fpos_m1 >= ram_rdata.file_start) && ({1'b0, fpos_m1} < f_end);
  assign m_e = cur_v && (ram_rdata.file == fid_r) &&
               (fpos_r >= ram_rdata.file_start) && ({1'b0, fpos_r} < f_end);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bem_pkg::S_IDLE:  if (in_valid) state_nxt = bem_pkg::S_SCAN;
      bem_pkg::S_SCAN:  if (!chk_v_r && rd_cnt_r == CW'(MAX_EXTENTS))
                          state_nxt = bem_pkg::S_WRITE;
      bem_pkg::S_WRITE: state_nxt = bem_pkg::S_OUT;
      bem_pkg::S_OUT:   if (!out_stall) state_nxt = bem_pkg::S_IDLE;
      default:          state_nxt = bem_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    if (state_r == bem_pkg::S_SCAN && rd_cnt_r != CW'(MAX_EXTENTS)) begin
      rd_cnt_nxt = rd_cnt_r + CW'(1);
    end
  end

  // write-back decision
  logic [31:0] len_a;
  logic        ext_ok;
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_idx_r;
    ram_wdata = '0;
    valid_nxt = valid_r;
    len_a     = hit_f_ent_r.length;
    ext_ok    = hit_f_r && (fpos_r != 32'd0) &&
                ({1'b0, pp_r} == {1'b0, hit_f_ent_r.parity_start} + {1'b0, len_a}) &&
                (len_a != 32'hFFFF_FFFF);
    if (state_r == bem_pkg::S_WRITE) begin
      unique case (cmd_r)
        bem_pkg::CMD_ALLOC: begin
          if (ext_ok) begin
            if (fpos_r == hit_f_ent_r.file_start + len_a) begin
              ram_we    = 1'b1;
              ram_waddr = hit_f_idx_r;
              ram_wdata = hit_f_ent_r;
              ram_wdata.length = len_a + 32'd1;
            end
          end else if (free_v_r) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_r;
            ram_wdata = '{parity_start: pp_r, file: fid_r, file_start: fpos_r,
                          length: 32'd1};
            valid_nxt[free_idx_r] = 1'b1;
          end
        end
        bem_pkg::CMD_DEALLOC: begin
          if (hit_p_r) begin
            ram_waddr = hit_p_idx_r;
            ram_wdata = hit_p_ent_r;
            ram_wdata.length = hit_p_ent_r.length - 32'd1;
            if (hit_p_ent_r.length == 32'd1) begin
              valid_nxt[hit_p_idx_r] = 1'b0;
            end else if (pp_r == hit_p_ent_r.parity_start) begin
              ram_we = 1'b1;
              ram_wdata.parity_start = hit_p_ent_r.parity_start + 32'd1;
              ram_wdata.file_start   = hit_p_ent_r.file_start + 32'd1;
            end else if (pp_r == hit_p_ent_r.parity_start + hit_p_ent_r.length - 32'd1) begin
              ram_we = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result of the command, formed in the write cycle
  logic [2:0]  st_nxt;
  logic [31:0] ff_nxt, fp_nxt, ppo_nxt, end_nxt;
  always_comb begin
    st_nxt  = bem_pkg::ST_OK;
    ff_nxt  = '0;
    fp_nxt  = '0;
    ppo_nxt = '0;
    end_nxt = '0;
    unique case (cmd_r)
      bem_pkg::CMD_ALLOC: begin
        if (ext_ok) begin
          if (fpos_r != hit_f_ent_r.file_start + len_a) st_nxt = bem_pkg::ST_BAD_EXTEND;
        end else if (!free_v_r) begin
          st_nxt = bem_pkg::ST_FULL;
        end
      end
      bem_pkg::CMD_DEALLOC: begin
        if (!hit_p_r) begin
          st_nxt = bem_pkg::ST_NOT_FOUND;
        end else if (hit_p_ent_r.length != 32'd1 && pp_r != hit_p_ent_r.parity_start &&
                     pp_r != hit_p_ent_r.parity_start + hit_p_ent_r.length - 32'd1) begin
          st_nxt = bem_pkg::ST_MIDDLE;
        end
      end
      bem_pkg::CMD_P2F: begin
        if (!hit_p_r) begin
          st_nxt = bem_pkg::ST_NOT_FOUND;
        end else begin
          ff_nxt = hit_p_ent_r.file;
          fp_nxt = hit_p_ent_r.file_start + (pp_r - hit_p_ent_r.parity_start);
        end
      end
      bem_pkg::CMD_F2P: begin
        if (!hit_e_r) begin
          st_nxt = bem_pkg::ST_NOT_FOUND;
        end else begin
          // hit_f_ent_r holds the exact-position match for this command
          ppo_nxt = hit_f_ent_r.parity_start + (fpos_r - hit_f_ent_r.file_start);
        end
      end
      bem_pkg::CMD_SIZE: end_nxt = best_r[32] ? 32'hFFFF_FFFF : best_r[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bem_pkg::S_IDLE;
      valid_r  <= '0;
      rd_cnt_r <= '0;
      chk_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      chk_v_r  <= (state_r == bem_pkg::S_SCAN) && (rd_cnt_r != CW'(MAX_EXTENTS));
      if (state_r == bem_pkg::S_IDLE) begin
        rd_cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= rd_cnt_r[AW-1:0];
    if (state_r == bem_pkg::S_IDLE) begin
      cmd_r    <= in_command;
      pp_r     <= in_parity_pos;
      fid_r    <= in_file_id;
      fpos_r   <= in_file_pos;
      hit_p_r  <= 1'b0;
      hit_f_r  <= 1'b0;
      hit_e_r  <= 1'b0;
      free_v_r <= 1'b0;
      best_r   <= '0;
    end else if (state_r == bem_pkg::S_SCAN && chk_v_r) begin
      if (m_p && !hit_p_r) begin
        hit_p_r     <= 1'b1;
        hit_p_idx_r <= chk_idx_r;
        hit_p_ent_r <= ram_rdata;
      end
      if (cmd_r == bem_pkg::CMD_F2P) begin
        if (m_e && !hit_e_r) begin
          hit_e_r     <= 1'b1;
          hit_f_ent_r <= ram_rdata;
        end
      end else if (m_f && !hit_f_r) begin
        hit_f_r     <= 1'b1;
        hit_f_idx_r <= chk_idx_r;
        hit_f_ent_r <= ram_rdata;
      end
      if (!valid_r[chk_idx_r] && !free_v_r) begin
        free_v_r   <= 1'b1;
        free_idx_r <= chk_idx_r;
      end
      if (cur_v && p_end > best_r) begin
        best_r <= p_end;
      end
    end
    if (state_r == bem_pkg::S_WRITE) begin
      st_r  <= st_nxt;
      ff_r  <= ff_nxt;
      fp_r  <= fp_nxt;
      ppo_r <= ppo_nxt;
      end_r <= end_nxt;
    end
  end

  assign in_stall             = (state_r != bem_pkg::S_IDLE);
  assign out_valid            = (state_r == bem_pkg::S_OUT);
  assign out_status           = st_r;
  assign out_found_file       = ff_r;
  assign out_found_file_pos   = fp_r;
  assign out_found_parity_pos = ppo_r;
  assign out_disk_extent_end  = end_r;

  // table only changes in the write-back cycle
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bem_pkg::S_WRITE) |=> $stable(valid_r))
    else $error("valid bits changed outside write-back");
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while result pending");
  a_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == bem_pkg::S_WRITE))
    else $error("memory written outside write-back");
  a_fail_nochange: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bem_pkg::S_WRITE && st_nxt != bem_pkg::ST_OK) |-> !ram_we)
    else $error("failed command wrote the table");

endmodule
